/* src/bcc_pkg.sv */
// Package for the button click classifier: configuration record, event codes,
// threshold defaults and counter limits. No dependencies.
package bcc_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int NOW_W         = 32;
	localparam int THR_W         = 16;
	localparam int CFG_IDX_W     = 2;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_SINGLE = 2'd0;
	localparam kind_t KIND_DOUBLE = 2'd1;
	localparam kind_t KIND_HOLD   = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_PIN_INV      = 2'd0;
	localparam cfg_idx_t REG_SETTLE_MS    = 2'd1;
	localparam cfg_idx_t REG_HOLD_MS      = 2'd2;
	localparam cfg_idx_t REG_DOUBLE_CLICK = 2'd3;

	localparam logic [1:0] CLICK_SAT = 2'd2;

	typedef struct packed {
		logic             pin_inv;
		logic [THR_W-1:0] settle_ms;
		logic [THR_W-1:0] hold_ms;
		logic [THR_W-1:0] gap_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		pin_inv:   1'b1,
		settle_ms: 16'd20,
		hold_ms:   16'd800,
		gap_ms:    16'd300
	};

	// one processed sample, handed from the debouncer to the click machine
	typedef struct packed {
		logic step;
		logic pressed;
	} deb_out_t;

	// event offered by the click machine for the result register
	typedef struct packed {
		logic  valid;
		kind_t kind;
	} event_t;

endpackage

/* src/bcc_debounce.sv */
// Debouncer of the button click classifier: polarity fix and stable level.
// Depends on bcc_pkg.
module bcc_debounce #(
	parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        pin_level,
	input  logic [TIME_BITS-1:0]        now,
	input  logic                        pin_inv,
	input  logic [bcc_pkg::THR_W-1:0]   settle_ms,
	output bcc_pkg::deb_out_t           deb
);

	logic                 last_raw_q;
	logic [TIME_BITS-1:0] change_time_q;
	logic                 stable_q;

	logic                 raw;
	logic [TIME_BITS-1:0] change_time_n;
	logic [TIME_BITS-1:0] elapsed;
	logic                 stable_n;

	always_comb begin
		raw           = pin_level ^ pin_inv;
		change_time_n = (raw != last_raw_q) ? now : change_time_q;
		elapsed       = now - change_time_n;
		stable_n      = (elapsed > TIME_BITS'(settle_ms)) ? raw : stable_q;
		deb.step      = step;
		deb.pressed   = stable_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			change_time_q <= '0;
			stable_q      <= 1'b0;
		end else if (step) begin
			last_raw_q    <= raw;
			change_time_q <= change_time_n;
			stable_q      <= stable_n;
		end
	end

endmodule

/* src/bcc_click_fsm.sv */
// Click state machine of the button click classifier: idle, pressed and wait,
// with hold detection and release counting. Depends on bcc_pkg.
module bcc_click_fsm #(
	parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bcc_pkg::deb_out_t           deb,
	input  logic [TIME_BITS-1:0]        now,
	input  logic [bcc_pkg::THR_W-1:0]   hold_ms,
	input  logic [bcc_pkg::THR_W-1:0]   gap_ms,
	output bcc_pkg::event_t             evt
);

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_PRESSED = 2'd1,
		MODE_WAIT    = 2'd2
	} mode_t;

	mode_t                mode_q, mode_n;
	logic [TIME_BITS-1:0] press_start_q, press_start_n;
	logic [TIME_BITS-1:0] wait_start_q, wait_start_n;
	logic                 hold_done_q, hold_done_n;
	logic [1:0]           count_q, count_n;

	logic [TIME_BITS-1:0] press_elapsed;
	logic [TIME_BITS-1:0] wait_elapsed;

	always_comb begin
		press_elapsed = now - press_start_q;
		wait_elapsed  = now - wait_start_q;

		mode_n        = mode_q;
		press_start_n = press_start_q;
		wait_start_n  = wait_start_q;
		hold_done_n   = hold_done_q;
		count_n       = count_q;
		evt.valid     = 1'b0;
		evt.kind      = bcc_pkg::KIND_SINGLE;

		case (mode_q)
			MODE_PRESSED: begin
				if (deb.pressed && !hold_done_q &&
				    press_elapsed >= TIME_BITS'(hold_ms)) begin
					hold_done_n = 1'b1;
					count_n     = '0;
					evt.valid   = 1'b1;
					evt.kind    = bcc_pkg::KIND_HOLD;
				end else if (!deb.pressed) begin
					if (hold_done_q) begin
						// release after a hold ends the sequence silently
						count_n = '0;
						mode_n  = MODE_IDLE;
					end else begin
						if (count_q < bcc_pkg::CLICK_SAT)
							count_n = count_q + 2'd1;
						wait_start_n = now;
						mode_n       = MODE_WAIT;
					end
				end
			end
			MODE_WAIT: begin
				if (deb.pressed) begin
					press_start_n = now;
					hold_done_n   = 1'b0;
					mode_n        = MODE_PRESSED;
				end else if (wait_elapsed >= TIME_BITS'(gap_ms)) begin
					evt.valid = 1'b1;
					evt.kind  = (count_q >= bcc_pkg::CLICK_SAT) ?
					            bcc_pkg::KIND_DOUBLE : bcc_pkg::KIND_SINGLE;
					count_n   = '0;
					mode_n    = MODE_IDLE;
				end
			end
			default: begin
				// idle, and the unused encoding read as idle
				if (deb.pressed) begin
					press_start_n = now;
					hold_done_n   = 1'b0;
					mode_n        = MODE_PRESSED;
				end else begin
					mode_n = MODE_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			press_start_q <= '0;
			wait_start_q  <= '0;
			hold_done_q   <= 1'b0;
			count_q       <= '0;
		end else if (deb.step) begin
			mode_q        <= mode_n;
			press_start_q <= press_start_n;
			wait_start_q  <= wait_start_n;
			hold_done_q   <= hold_done_n;
			count_q       <= count_n;
		end
	end

endmodule

/* src/button_click_classifier.sv */
// Top level of the button click classifier: stream ports, configuration
// registers, input and result registers. Depends on bcc_pkg, bcc_debounce, bcc_click_fsm.
//
// Usage: each slave-side beat carries one pin sample and its millisecond
// timestamp; the master side carries click events (single, double, hold).
// A sample produces at most one event; most produce none.
// The sample is held in an input register, then debounced and classified
// combinationally and written to the result register, which drives m_tvalid.
// One sample is taken per cycle while no event waits on a low m_tready.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user
// must write them only while idle, which the block does not enforce;
// only the low bits each register needs are kept.
// Reset clears the debouncer and the click machine to idle, empties both
// registers and loads the threshold defaults (active low, 20, 800, 300 ms).
// When m_tready is low with an event waiting, the held sample stays in the
// input register and s_tready drops until the event is taken.
module button_click_classifier #(
	parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,   // pin_level [0], now_ms [32:1]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // click_kind [1:0]
	input  logic                          cfg_we,
	input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bcc_pkg::THR_W-1:0]     cfg_wdata
);

	bcc_pkg::cfg_t cfg_q;

	logic                          vld_s1;
	logic                          pin_s1;
	logic [bcc_pkg::NOW_W-1:0]     now_s1;

	logic                          out_vld_q;
	bcc_pkg::kind_t                kind_q;

	logic                          out_free;
	logic                          step;
	logic [TIME_BITS-1:0]          now;
	bcc_pkg::deb_out_t             deb;
	bcc_pkg::event_t               evt;

	assign out_free = !out_vld_q || m_tready;
	assign step     = vld_s1 && out_free;
	assign s_tready = !vld_s1 || out_free;
	assign now      = TIME_BITS'(now_s1);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, kind_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= bcc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bcc_pkg::REG_PIN_INV:      cfg_q.pin_inv   <= cfg_wdata[0];
				bcc_pkg::REG_SETTLE_MS:    cfg_q.settle_ms <= cfg_wdata;
				bcc_pkg::REG_HOLD_MS:      cfg_q.hold_ms   <= cfg_wdata;
				bcc_pkg::REG_DOUBLE_CLICK: cfg_q.gap_ms    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register: load a beat when the slot is empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pin_s1 <= s_tdata[0];
			now_s1 <= s_tdata[32:1];
		end
	end

	bcc_debounce #(
		.TIME_BITS (TIME_BITS)
	) u_debounce (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.pin_level (pin_s1),
		.now       (now),
		.pin_inv   (cfg_q.pin_inv),
		.settle_ms (cfg_q.settle_ms),
		.deb       (deb)
	);

	bcc_click_fsm #(
		.TIME_BITS (TIME_BITS)
	) u_click_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.deb     (deb),
		.now     (now),
		.hold_ms (cfg_q.hold_ms),
		.gap_ms  (cfg_q.gap_ms),
		.evt     (evt)
	);

	// result register: drop a taken beat, load a new event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step && evt.valid) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && evt.valid)
			kind_q <= evt.kind;
	end

endmodule
